// ----- rtl/sdi_pkg.sv -----
package sdi_pkg;

  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 64;
  localparam int WIDE_W      = VALUE_W + 4;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_IDX_BIT = 2;

  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [WIDE_W-1:0]     wide_t;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_FIRST       = 2'd0,
    PH_AFTER_MINUS = 2'd1,
    PH_DIGITS      = 2'd2
  } phase_t;

  localparam logic REG_SIGNED_MODE = 1'b0;

  localparam char_t  CH_ZERO    = 8'h30;
  localparam char_t  CH_ONE     = 8'h31;
  localparam char_t  CH_NINE    = 8'h39;
  localparam char_t  CH_MINUS   = 8'h2D;
  localparam logic [3:0] DIGIT_MASK = 4'hF;
  localparam value_t NEG_LIMIT  = 64'h8000_0000_0000_0000;
  localparam value_t POS_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

// ----- rtl/sdi_if.sv -----
interface sdi_in_if;
  import sdi_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_byte;
  logic  last_byte;

  modport source(output valid, output char_byte, output last_byte, input ready);
  modport sink(input valid, input char_byte, input last_byte, output ready);
endinterface

interface sdi_out_if;
  import sdi_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  value_t  value_bits;

  modport source(output valid, output status, output value_bits, input ready);
  modport sink(input valid, input status, input value_bits, output ready);
endinterface

// ----- rtl/strict_decimal_to_int64.sv -----
// Pipeline: an accepted byte is held in the input register and parsed from
// there; a final byte's result goes to the result register (two register stages).
// Throughput: one byte per cycle when the result is not stalled, set by the
// single accumulate step (value * 10 + digit with exact overflow) between input
// and result registers. Reset (rst_n low, synchronous): pipeline emptied,
// string state cleared, signed_mode set to 1.
module strict_decimal_to_int64 (
  input  logic               clk,
  input  logic               rst_n,
  sdi_in_if.sink             in_chan,
  sdi_out_if.source          out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  sdi_pkg::cfg_addr_t paddr,
  input  sdi_pkg::cfg_data_t pwdata,
  output sdi_pkg::cfg_data_t prdata,
  output logic               pready
);
  import sdi_pkg::*;

  logic    signed_mode_r;

  logic    s0_valid_r;
  char_t   s0_char_r;
  logic    s0_last_r;

  value_t  acc_r, acc_nxt;
  logic    neg_r, neg_nxt;
  phase_t  phase_r, phase_nxt;
  logic    fmt_r, fmt_nxt;
  logic    ovf_r, ovf_nxt;

  logic    out_valid_r;
  status_t out_status_r, status_nxt;
  value_t  out_value_r, value_nxt;

  logic    stall, proc, cfg_wr;
  logic    is_digit, is_nonzero;
  wide_t   prod;

  assign stall         = out_valid_r & ~out_chan.ready;
  assign proc          = s0_valid_r & ~stall;
  assign in_chan.ready = ~(s0_valid_r & stall);

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.value_bits = out_value_r;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[REG_IDX_BIT] == REG_SIGNED_MODE);
  assign prdata = (paddr[REG_IDX_BIT] == REG_SIGNED_MODE) ?
                  {{(CFG_DATA_W-1){1'b0}}, signed_mode_r} : '0;

  assign is_digit   = (s0_char_r >= CH_ZERO) && (s0_char_r <= CH_NINE);
  assign is_nonzero = (s0_char_r >= CH_ONE) && (s0_char_r <= CH_NINE);
  assign prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
              + {{(WIDE_W-4){1'b0}}, s0_char_r[3:0] & DIGIT_MASK};

  always_comb begin
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    phase_nxt = phase_r;
    fmt_nxt   = fmt_r;
    ovf_nxt   = ovf_r;
    if (!(fmt_r || ovf_r)) begin
      case (phase_r)
        PH_FIRST: begin
          if (s0_char_r == CH_ZERO) begin
            if (!s0_last_r) fmt_nxt = 1'b1;
          end else if (s0_char_r == CH_MINUS) begin
            if (signed_mode_r && !s0_last_r) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_AFTER_MINUS;
            end else begin
              fmt_nxt = 1'b1;
            end
          end else if (is_nonzero) begin
            acc_nxt   = {{(VALUE_W-4){1'b0}}, s0_char_r[3:0] & DIGIT_MASK};
            phase_nxt = PH_DIGITS;
          end else begin
            fmt_nxt = 1'b1;
          end
        end
        PH_AFTER_MINUS: begin
          if (is_nonzero) begin
            acc_nxt   = {{(VALUE_W-4){1'b0}}, s0_char_r[3:0] & DIGIT_MASK};
            phase_nxt = PH_DIGITS;
          end else begin
            fmt_nxt = 1'b1;
          end
        end
        default: begin
          if (!is_digit) begin
            fmt_nxt = 1'b1;
          end else if (prod[WIDE_W-1:VALUE_W] != '0) begin
            ovf_nxt = 1'b1;
          end else begin
            acc_nxt = prod[VALUE_W-1:0];
          end
        end
      endcase
    end

    status_nxt = ST_OK;
    value_nxt  = '0;
    if (fmt_nxt) begin
      status_nxt = ST_FORMAT;
    end else if (ovf_nxt) begin
      status_nxt = ST_RANGE;
    end else if (neg_nxt) begin
      if (acc_nxt > NEG_LIMIT) status_nxt = ST_RANGE;
      else value_nxt = '0 - acc_nxt;
    end else if (signed_mode_r && (acc_nxt > POS_LIMIT)) begin
      status_nxt = ST_RANGE;
    end else begin
      value_nxt = acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b1;
      s0_valid_r    <= 1'b0;
      acc_r         <= '0;
      neg_r         <= 1'b0;
      phase_r       <= PH_FIRST;
      fmt_r         <= 1'b0;
      ovf_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) signed_mode_r <= pwdata[0];
      if (in_chan.ready) s0_valid_r <= in_chan.valid;
      if (proc && s0_last_r) begin
        acc_r       <= '0;
        neg_r       <= 1'b0;
        phase_r     <= PH_FIRST;
        fmt_r       <= 1'b0;
        ovf_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (proc) begin
          acc_r   <= acc_nxt;
          neg_r   <= neg_nxt;
          phase_r <= phase_nxt;
          fmt_r   <= fmt_nxt;
          ovf_r   <= ovf_nxt;
        end
        if (out_chan.ready) out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s0_char_r <= in_chan.char_byte;
      s0_last_r <= in_chan.last_byte;
    end
    if (proc && s0_last_r) begin
      out_status_r <= status_nxt;
      out_value_r  <= value_nxt;
    end
  end

endmodule

// ----- rtl/sdi_checker.sv -----
module sdi_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input sdi_pkg::status_t out_status,
  input sdi_pkg::value_t  out_value
);
  import sdi_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_value == '0)
    else $error("rejected string carries a nonzero value");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word present after reset");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked result");

endmodule

bind strict_decimal_to_int64 sdi_checker u_sdi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_status (out_chan.status),
  .out_value  (out_chan.value_bits)
);
